FILE: hw/rtl/isc_pkg.sv
`timescale 1ns / 1ps

package isc_pkg;

  // input beat: raw device words in register order
  typedef struct packed {
    logic signed [15:0] accel_word_0;
    logic signed [15:0] accel_word_1;
    logic signed [15:0] accel_word_2;
    logic signed [15:0] temp_word;
    logic signed [15:0] gyro_word_0;
    logic signed [15:0] gyro_word_1;
    logic signed [15:0] gyro_word_2;
  } isc_in_t;

  // output beat: q16.16 motion, q8.8 temperature
  typedef struct packed {
    logic signed [31:0] accel_out_x;
    logic signed [31:0] accel_out_y;
    logic signed [31:0] accel_out_z;
    logic signed [31:0] rate_out_x;
    logic signed [31:0] rate_out_y;
    logic signed [31:0] rate_out_z;
    logic signed [15:0] temp_out;
  } isc_out_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_MODE       = 3'd0,
    REG_ACCEL_BIAS = 3'd1,
    REG_GYRO_BIAS  = 3'd2,
    REG_ROW_X      = 3'd3,
    REG_ROW_Y      = 3'd4,
    REG_ROW_Z      = 3'd5
  } isc_reg_e;

  // pipeline advance controls shared by all stages
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
    logic en4;
    logic v3;
  } isc_adv_t;

  // bias-corrected acceleration, q11.16
  typedef logic signed [26:0] isc_d_t;

  // what one lane hands to the merge stage
  typedef struct packed {
    logic signed [42:0] p0;
    logic signed [42:0] p1;
    logic signed [42:0] p2;
    logic               neg;
    logic signed [31:0] rate;
  } isc_lane_t;

  // temperature quotient estimate and check terms
  typedef struct packed {
    logic signed [31:0] n;
    logic signed [32:0] qd;
    logic signed [16:0] q;
  } isc_temp_t;

  // 9.80665 m/s^2 per g in q.24
  localparam logic [27:0] GravQ24 = 28'd164528285;

  // gyro scale: round((pi q61 >> 13) / (18 * lsb per deg/s in tenths))
  localparam logic [63:0] PiQ61    = 64'd7244019458077122842;
  localparam logic [63:0] Pi48     = PiQ61 >> 13;
  localparam logic [63:0] GyroDen0 = 64'd18 * 64'd1310;
  localparam logic [63:0] GyroDen1 = 64'd18 * 64'd655;
  localparam logic [63:0] GyroDen2 = 64'd18 * 64'd328;
  localparam logic [63:0] GyroDen3 = 64'd18 * 64'd164;
  localparam logic [63:0] GyroK0   = (Pi48 + GyroDen0 / 64'd2) / GyroDen0;
  localparam logic [63:0] GyroK1   = (Pi48 + GyroDen1 / 64'd2) / GyroDen1;
  localparam logic [63:0] GyroK2   = (Pi48 + GyroDen2 / 64'd2) / GyroDen2;
  localparam logic [63:0] GyroK3   = (Pi48 + GyroDen3 / 64'd2) / GyroDen3;

  // temperature: floor((2*raw*25600 + 33387) / 66774) + 5376
  localparam logic [63:0] TempRecipW = (64'd1 << 46) / 64'd66774;
  localparam logic [30:0] TempRecip  = TempRecipW[30:0];
  localparam logic [16:0] TempDiv    = 17'd66774;

  function automatic logic [38:0] gyro_k(input logic [1:0] rng);
    logic [38:0] k;
    case (rng)
      2'd0:    k = GyroK0[38:0];
      2'd1:    k = GyroK1[38:0];
      2'd2:    k = GyroK2[38:0];
      2'd3:    k = GyroK3[38:0];
      default: k = GyroK0[38:0];
    endcase
    return k;
  endfunction

endpackage

FILE: hw/rtl/isc_lane.sv
`timescale 1ns / 1ps

module isc_lane (
  input  logic                   clk_i,
  input  isc_pkg::isc_adv_t      adv_i,
  input  logic signed [15:0]     accel_raw_i,
  input  logic signed [15:0]     gyro_raw_i,
  input  logic [1:0]             accel_range_i,
  input  logic [1:0]             gyro_range_i,
  input  logic                   neg_i,
  input  logic [20:0]            accel_bias_i,
  input  logic [20:0]            gyro_bias_i,
  input  logic [47:0]            row_i,
  input  isc_pkg::isc_d_t [2:0]  d_all_i,
  output isc_pkg::isc_d_t        d_o,
  output isc_pkg::isc_lane_t     lane_o
);
  import isc_pkg::*;

  logic [38:0]        gk;
  logic signed [44:0] aprod_d, aprod_q;
  logic signed [36:0] glo_d, glo_q;
  logic signed [35:0] ghi_d, ghi_q;

  logic [4:0]         ashift;
  logic signed [44:0] ahalf;
  logic signed [44:0] around;
  logic signed [24:0] accel;
  isc_d_t             d_d, d_q;

  logic signed [55:0] gfull;
  logic signed [55:0] ground;
  logic signed [23:0] gval;
  logic signed [25:0] gsum;
  logic signed [26:0] grate;
  logic signed [31:0] rate_d, rate_q;

  isc_lane_t          lane_d, lane_q;

  // stage 1: range scaling products, gyro factor split in two halves
  assign gk      = gyro_k(gyro_range_i);
  assign aprod_d = accel_raw_i * $signed({1'b0, GravQ24});
  assign glo_d   = gyro_raw_i * $signed({1'b0, gk[19:0]});
  assign ghi_d   = gyro_raw_i * $signed({1'b0, gk[38:20]});

  always_ff @(posedge clk_i) begin
    if (adv_i.en1) begin
      aprod_q <= aprod_d;
      glo_q   <= glo_d;
      ghi_q   <= ghi_d;
    end
  end

  // stage 2: accel rounding shift and bias removal
  always_comb begin
    ashift = 5'd22 - {3'b000, accel_range_i};
    ahalf  = 45'sd1 <<< (ashift - 5'd1);
    around = (aprod_q + ahalf) >>> ashift;
    accel  = around[24:0];
    d_d    = $signed({{2{accel[24]}}, accel})
           - $signed({{2{accel_bias_i[20]}}, accel_bias_i, 4'b0000});
  end

  // stage 2: gyro recombine, round, bias and sign
  always_comb begin
    gfull  = $signed({ghi_q, 20'b0}) + $signed({{19{glo_q[36]}}, glo_q});
    ground = (gfull + 56'sd2147483648) >>> 32;
    gval   = ground[23:0];
    gsum   = $signed({{2{gval[23]}}, gval})
           + $signed({gyro_bias_i[20], gyro_bias_i, 4'b0000});
    grate  = neg_i ? -$signed({gsum[25], gsum}) : $signed({gsum[25], gsum});
    rate_d = $signed({{5{grate[26]}}, grate});
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.en2) begin
      d_q    <= d_d;
      rate_q <= rate_d;
    end
  end

  assign d_o = d_q;

  // stage 3: one matrix row against all corrected axes
  always_comb begin
    lane_d.p0   = $signed(row_i[15:0])  * $signed(d_all_i[0]);
    lane_d.p1   = $signed(row_i[31:16]) * $signed(d_all_i[1]);
    lane_d.p2   = $signed(row_i[47:32]) * $signed(d_all_i[2]);
    lane_d.neg  = neg_i;
    lane_d.rate = rate_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.en3) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

FILE: hw/rtl/isc_temp.sv
`timescale 1ns / 1ps

module isc_temp (
  input  logic               clk_i,
  input  isc_pkg::isc_adv_t  adv_i,
  input  logic signed [15:0] temp_raw_i,
  output isc_pkg::isc_temp_t temp_o
);
  import isc_pkg::*;

  logic signed [31:0] scaled;
  logic signed [31:0] n_d, n1_q, n2_q;
  logic signed [62:0] rprod;
  logic signed [62:0] rshift;
  logic signed [16:0] q_d, q2_q;
  logic signed [34:0] qprod;
  isc_temp_t          temp_d, temp_q;

  // stage 1: raw * 25600 as shift-add, doubled plus half divisor
  always_comb begin
    scaled = $signed({{2{temp_raw_i[15]}}, temp_raw_i, 14'b0})
           + $signed({{3{temp_raw_i[15]}}, temp_raw_i, 13'b0})
           + $signed({{6{temp_raw_i[15]}}, temp_raw_i, 10'b0});
    n_d    = (scaled <<< 1) + 32'sd33387;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.en1) begin
      n1_q <= n_d;
    end
  end

  // stage 2: quotient estimate by reciprocal, off by at most one
  always_comb begin
    rprod  = n1_q * $signed({1'b0, TempRecip});
    rshift = rprod >>> 46;
    q_d    = rshift[16:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.en2) begin
      n2_q <= n1_q;
      q2_q <= q_d;
    end
  end

  // stage 3: back-multiply for the remainder check
  always_comb begin
    qprod     = q2_q * $signed({1'b0, TempDiv});
    temp_d.n  = n2_q;
    temp_d.qd = qprod[32:0];
    temp_d.q  = q2_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.en3) begin
      temp_q <= temp_d;
    end
  end

  assign temp_o = temp_q;

endmodule

FILE: hw/rtl/isc_merge.sv
`timescale 1ns / 1ps

module isc_merge (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  isc_pkg::isc_adv_t        adv_i,
  input  isc_pkg::isc_lane_t [2:0] lanes_i,
  input  isc_pkg::isc_temp_t       temp_i,
  output logic                     out_valid_o,
  output isc_pkg::isc_out_t        out_data_o
);
  import isc_pkg::*;

  localparam logic signed [32:0] DivS  = 33'sd66774;
  localparam logic signed [32:0] DivS2 = 33'sd133548;

  logic signed [31:0] accel [3];
  logic signed [44:0] rsum  [3];
  logic signed [44:0] rrnd  [3];
  logic signed [32:0] rsgn  [3];
  logic signed [32:0] rem;
  logic signed [16:0] qfix;
  logic signed [16:0] tsum;
  logic               out_valid_q;
  isc_out_t           out_d, out_q;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v > 33'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -33'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // row sums, rounding shift, optional sign flip, clamp
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rsum[i]  = $signed({{2{lanes_i[i].p0[42]}}, lanes_i[i].p0})
               + $signed({{2{lanes_i[i].p1[42]}}, lanes_i[i].p1})
               + $signed({{2{lanes_i[i].p2[42]}}, lanes_i[i].p2});
      rrnd[i]  = (rsum[i] + 45'sd8192) >>> 14;
      rsgn[i]  = lanes_i[i].neg ? -rrnd[i][32:0] : rrnd[i][32:0];
      accel[i] = sat32(rsgn[i]);
    end
  end

  // temperature quotient correction and offset
  always_comb begin
    rem = $signed({temp_i.n[31], temp_i.n}) - temp_i.qd;
    if (rem < 33'sd0) begin
      qfix = temp_i.q - 17'sd1;
    end else if (rem >= DivS) begin
      qfix = temp_i.q + 17'sd1;
    end else begin
      qfix = temp_i.q;
    end
    tsum = qfix + 17'sd5376;
  end

  // pack the output beat
  always_comb begin
    out_d.accel_out_x = accel[0];
    out_d.accel_out_y = accel[1];
    out_d.accel_out_z = accel[2];
    out_d.rate_out_x  = lanes_i[0].rate;
    out_d.rate_out_y  = lanes_i[1].rate;
    out_d.rate_out_z  = lanes_i[2].rate;
    out_d.temp_out    = tsum[15:0];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_i.en4) begin
      out_valid_q <= adv_i.v3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.en4) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // reciprocal estimate keeps the remainder within one divisor step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i.v3 |-> (rem >= -DivS && rem < DivS2))
    else $error("temperature quotient estimate off by more than one");

  // a finished item moving in must show up at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i.v3 && adv_i.en4 |=> out_valid_o)
    else $error("result lost entering output register");

  // a stalled output beat holds steady until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !adv_i.en4 |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

endmodule

FILE: hw/rtl/imu_sample_calibrate.sv
`timescale 1ns / 1ps

// Six-axis sample calibration pipeline.
// Input channel: in_valid_i / in_ready_o carry one raw sample beat (three
// accel words, temperature word, three gyro words, device register order).
// Output channel: out_valid_o / out_ready_i carry one calibrated beat per
// sample: q16.16 acceleration and angular rate per axis, q8.8 temperature.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_index_i at
// the clock edge; write only while no sample is in flight.
// Path: the edge that takes a sample loads it into the first of three
// compute stages; it then moves through the other two and into the output
// register, where its result is valid.
// Throughput: one sample per cycle when not stalled; three axis lanes and
// the temperature unit run side by side, each stage holding one sample.
// Stalls: when the receiver holds out_ready_i low, stages fill up behind
// the output register; in_ready_o stays high while any stage has a bubble.
// Reset: clears all stage valids and loads mode 0, zero biases and the
// identity matrix.
module imu_sample_calibrate (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  isc_pkg::isc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output isc_pkg::isc_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [62:0]       cfg_wdata_i
);
  import isc_pkg::*;

  logic [6:0]       mode_q;
  logic [62:0]      abias_q;
  logic [62:0]      gbias_q;
  logic [2:0][47:0] row_q;

  logic             v1_q, v2_q, v3_q;
  isc_adv_t         adv;

  logic signed [15:0] accel_raw [3];
  logic signed [15:0] gyro_raw  [3];
  isc_d_t [2:0]       d_all;
  isc_lane_t [2:0]    lanes;
  isc_temp_t          temp;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 7'd0;
      abias_q  <= 63'd0;
      gbias_q  <= 63'd0;
      row_q[0] <= 48'h0000_0000_4000;
      row_q[1] <= 48'h0000_4000_0000;
      row_q[2] <= 48'h4000_0000_0000;
    end else if (cfg_we_i) begin
      case (isc_reg_e'(cfg_index_i))
        REG_MODE:       mode_q   <= cfg_wdata_i[6:0];
        REG_ACCEL_BIAS: abias_q  <= cfg_wdata_i;
        REG_GYRO_BIAS:  gbias_q  <= cfg_wdata_i;
        REG_ROW_X:      row_q[0] <= cfg_wdata_i[47:0];
        REG_ROW_Y:      row_q[1] <= cfg_wdata_i[47:0];
        REG_ROW_Z:      row_q[2] <= cfg_wdata_i[47:0];
        default:        ;
      endcase
    end
  end

  // stage advance: a stage moves when empty or when the next one moves
  always_comb begin
    adv.en4 = !out_valid_o || out_ready_i;
    adv.en3 = !v3_q || adv.en4;
    adv.en2 = !v2_q || adv.en3;
    adv.en1 = !v1_q || adv.en2;
    adv.v3  = v3_q;
  end

  assign in_ready_o = adv.en1;

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv.en1) begin
        v1_q <= in_valid_i;
      end
      if (adv.en2) begin
        v2_q <= v1_q;
      end
      if (adv.en3) begin
        v3_q <= v2_q;
      end
    end
  end

  // device word 1 feeds x, word 0 feeds y, word 2 feeds z
  assign accel_raw[0] = in_data_i.accel_word_1;
  assign accel_raw[1] = in_data_i.accel_word_0;
  assign accel_raw[2] = in_data_i.accel_word_2;
  assign gyro_raw[0]  = in_data_i.gyro_word_1;
  assign gyro_raw[1]  = in_data_i.gyro_word_0;
  assign gyro_raw[2]  = in_data_i.gyro_word_2;

  // one lane per axis
  for (genvar i = 0; i < 3; i++) begin : g_lane
    isc_lane u_lane (
      .clk_i        (clk_i),
      .adv_i        (adv),
      .accel_raw_i  (accel_raw[i]),
      .gyro_raw_i   (gyro_raw[i]),
      .accel_range_i(mode_q[1:0]),
      .gyro_range_i (mode_q[3:2]),
      .neg_i        (mode_q[4+i]),
      .accel_bias_i (abias_q[21*i +: 21]),
      .gyro_bias_i  (gbias_q[21*i +: 21]),
      .row_i        (row_q[i]),
      .d_all_i      (d_all),
      .d_o          (d_all[i]),
      .lane_o       (lanes[i])
    );
  end

  // temperature unit
  isc_temp u_temp (
    .clk_i     (clk_i),
    .adv_i     (adv),
    .temp_raw_i(in_data_i.temp_word),
    .temp_o    (temp)
  );

  // row sums, temperature fix-up and output register
  isc_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .lanes_i    (lanes),
    .temp_i     (temp),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o)
  );

  // a taken beat occupies the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v1_q)
    else $error("accepted beat missing from first stage");

  // a full, stalled pipeline must refuse input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && v2_q && v3_q && out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while pipeline is full");

  // a stage with a bubble ahead never blocks the one behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v2_q |-> adv.en1)
    else $error("first stage blocked behind an empty stage");

endmodule
